// File: hdl/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 2;
  localparam int PRIO_W   = 8;
  localparam int CLIENT_W = 16;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // one stored entry of the sorted row
  typedef struct packed {
    logic                valid;
    logic [PRIO_W-1:0]   prio;
    logic [CLIENT_W-1:0] client;
  } entry_t;

  // per-item command broadcast to every cell
  typedef struct packed {
    logic               ins;
    logic               ext;
    logic               clr;
    logic [PRIO_W-1:0]  new_prio;
    logic [CLIENT_W-1:0] new_client;
  } cell_ctl_t;

  typedef struct packed {
    logic                head_valid;
    logic [PRIO_W-1:0]   head_priority;
    logic [CLIENT_W-1:0] head_client;
    logic                popped_valid;
    logic [PRIO_W-1:0]   popped_priority;
    logic [CLIENT_W-1:0] popped_client;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_full;
    logic                is_empty;
    logic                insert_dropped;
  } result_t;

endpackage

// File: hdl/spq_in_if.sv
interface spq_in_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::OP_W-1:0]      opcode;
  logic [spq_pkg::PRIO_W-1:0]    priority_req;
  logic [spq_pkg::CLIENT_W-1:0]  client_handle;

  modport source (output valid, output opcode, output priority_req, output client_handle,
                  input ready);
  modport sink   (input valid, input opcode, input priority_req, input client_handle,
                  output ready);
endinterface

// File: hdl/spq_out_if.sv
interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          head_valid;
  logic [spq_pkg::PRIO_W-1:0]    head_priority;
  logic [spq_pkg::CLIENT_W-1:0]  head_client;
  logic                          popped_valid;
  logic [spq_pkg::PRIO_W-1:0]    popped_priority;
  logic [spq_pkg::CLIENT_W-1:0]  popped_client;
  logic [spq_pkg::COUNT_W-1:0]   entry_count;
  logic                          is_full;
  logic                          is_empty;
  logic                          insert_dropped;

  modport source (output valid, output head_valid, output head_priority, output head_client,
                  output popped_valid, output popped_priority, output popped_client,
                  output entry_count, output is_full, output is_empty,
                  output insert_dropped, input ready);
  modport sink   (input valid, input head_valid, input head_priority, input head_client,
                  input popped_valid, input popped_priority, input popped_client,
                  input entry_count, input is_full, input is_empty,
                  input insert_dropped, output ready);
endinterface

// File: hdl/spq_cell.sv
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_ctl_t ctl_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               left_le_i,
  input  spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t    ent_o,
  output spq_pkg::entry_t    nxt_o,
  output logic               le_o
);

  logic                         valid_r, valid_nxt;
  logic [spq_pkg::PRIO_W-1:0]   prio_r, prio_nxt;
  logic [spq_pkg::CLIENT_W-1:0] client_r, client_nxt;

  // entry stays put on insert when it is served no later than the new one
  assign le_o = valid_r && (prio_r <= ctl_i.new_prio);

  always_comb begin
    valid_nxt  = valid_r;
    prio_nxt   = prio_r;
    client_nxt = client_r;
    if (ctl_i.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl_i.ext) begin
      valid_nxt  = right_i.valid;
      prio_nxt   = right_i.prio;
      client_nxt = right_i.client;
    end else if (ctl_i.ins && !le_o) begin
      if (left_le_i) begin
        valid_nxt  = 1'b1;
        prio_nxt   = ctl_i.new_prio;
        client_nxt = ctl_i.new_client;
      end else begin
        valid_nxt  = left_i.valid;
        prio_nxt   = left_i.prio;
        client_nxt = left_i.client;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r   <= prio_nxt;
    client_r <= client_nxt;
  end

  assign ent_o = '{valid: valid_r, prio: prio_r, client: client_r};
  assign nxt_o = '{valid: valid_nxt, prio: prio_nxt, client: client_nxt};

endmodule

// File: hdl/sorted_priority_queue.sv
// result: valid in the output register in the cycle after the input transfer
// throughput: one item per cycle while the output side is ready; every cell of the sorted row updates in the same cycle
// input is taken while the output register is empty or being drained in the same cycle
// reset (synchronous, rst_n low) empties the queue and the output register;
// slot contents are not cleared, only the per-cell valid bits
module sorted_priority_queue (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);

  // stored entry count and registered result
  logic [spq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  spq_pkg::result_t          res_r, res_nxt;

  logic                accept;
  spq_pkg::cell_ctl_t  ctl;
  logic                full, empty, dropped;

  // row of cells: slot 0 is the head
  spq_pkg::entry_t cur   [spq_pkg::CAPACITY];
  spq_pkg::entry_t nxt   [spq_pkg::CAPACITY];
  logic            le    [spq_pkg::CAPACITY];

  // output register frees up when empty or when the sink takes it now
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full  = (count_r == spq_pkg::CAP_CNT);
  assign empty = (count_r == '0);

  // decode the item into a command seen by every cell
  always_comb begin
    ctl            = '0;
    dropped        = 1'b0;
    ctl.new_prio   = in_ch.priority_req;
    ctl.new_client = in_ch.client_handle;
    if (accept) begin
      case (in_ch.opcode)
        spq_pkg::OP_INSERT: begin
          if (full) begin
            dropped = 1'b1;
          end else begin
            ctl.ins = 1'b1;
          end
        end
        spq_pkg::OP_EXTRACT: begin
          ctl.ext = !empty;
        end
        spq_pkg::OP_CLEAR: begin
          ctl.clr = 1'b1;
        end
        default: begin
          // unused opcode leaves the queue untouched
        end
      endcase
    end
  end

  // each cell looks at its left neighbor on insert and its right one on extract
  for (genvar g = 0; g < spq_pkg::CAPACITY; g++) begin : g_row
    spq_pkg::entry_t left_ent, right_ent;
    logic            left_le;

    if (g == 0) begin : g_first
      assign left_ent = '0;
      assign left_le  = 1'b1;
    end else begin : g_mid
      assign left_ent = cur[g-1];
      assign left_le  = le[g-1];
    end

    if (g == spq_pkg::CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cur[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl),
      .left_i    (left_ent),
      .left_le_i (left_le),
      .right_i   (right_ent),
      .ent_o     (cur[g]),
      .nxt_o     (nxt[g]),
      .le_o      (le[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.clr) begin
      count_nxt = '0;
    end else if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.ext) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // result reflects the state after the item; head fields read zero when empty
  always_comb begin
    logic [spq_pkg::CNT_W+spq_pkg::COUNT_W-1:0] cnt_wide;
    cnt_wide                = {{spq_pkg::COUNT_W{1'b0}}, count_nxt};
    res_nxt                 = '0;
    res_nxt.head_valid      = (count_nxt != '0);
    if (count_nxt != '0) begin
      res_nxt.head_priority = nxt[0].prio;
      res_nxt.head_client   = nxt[0].client;
    end
    res_nxt.popped_valid    = ctl.ext;
    if (ctl.ext) begin
      res_nxt.popped_priority = cur[0].prio;
      res_nxt.popped_client   = cur[0].client;
    end
    res_nxt.entry_count     = cnt_wide[spq_pkg::COUNT_W-1:0];
    res_nxt.is_full         = (count_nxt == spq_pkg::CAP_CNT);
    res_nxt.is_empty        = (count_nxt == '0);
    res_nxt.insert_dropped  = dropped;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload only loads on an input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.head_valid      = res_r.head_valid;
  assign out_ch.head_priority   = res_r.head_priority;
  assign out_ch.head_client     = res_r.head_client;
  assign out_ch.popped_valid    = res_r.popped_valid;
  assign out_ch.popped_priority = res_r.popped_priority;
  assign out_ch.popped_client   = res_r.popped_client;
  assign out_ch.entry_count     = res_r.entry_count;
  assign out_ch.is_full         = res_r.is_full;
  assign out_ch.is_empty        = res_r.is_empty;
  assign out_ch.insert_dropped  = res_r.insert_dropped;

endmodule

// File: tb/sv/spq_tb_pkg.sv
`timescale 1ns / 100ps

package spq_tb_pkg;

  // opcode three carries no operation
  localparam logic [spq_pkg::OP_W-1:0] OP_NOP = 2'd3;

  class spq_scoreboard;

    logic [spq_pkg::PRIO_W-1:0]   slot_prio   [spq_pkg::CAPACITY];
    logic [spq_pkg::CLIENT_W-1:0] slot_client [spq_pkg::CAPACITY];
    int unsigned                  stored;
    int unsigned                  failures;
    spq_pkg::result_t             expected_status[$];

    function new();
      stored   = 0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    // update the sorted row for one accepted transfer and queue the status it yields
    function void accept_request(logic [spq_pkg::OP_W-1:0] op,
                                 logic [spq_pkg::PRIO_W-1:0] prio,
                                 logic [spq_pkg::CLIENT_W-1:0] client);
      spq_pkg::result_t r;
      int unsigned      pos;
      int unsigned      k;
      r = '0;
      case (op)
        spq_pkg::OP_INSERT: begin
          if (stored >= spq_pkg::CAPACITY) begin
            r.insert_dropped = 1'b1;
          end else begin
            // after every entry of lower or equal priority
            pos = 0;
            while (pos < stored && slot_prio[pos] <= prio) pos++;
            for (k = stored; k > pos; k--) begin
              slot_prio[k]   = slot_prio[k-1];
              slot_client[k] = slot_client[k-1];
            end
            slot_prio[pos]   = prio;
            slot_client[pos] = client;
            stored++;
          end
        end
        spq_pkg::OP_EXTRACT: begin
          if (stored > 0) begin
            r.popped_valid    = 1'b1;
            r.popped_priority = slot_prio[0];
            r.popped_client   = slot_client[0];
            for (k = 0; k + 1 < stored; k++) begin
              slot_prio[k]   = slot_prio[k+1];
              slot_client[k] = slot_client[k+1];
            end
            stored--;
          end
        end
        spq_pkg::OP_CLEAR: stored = 0;
        default: ;
      endcase
      if (stored > 0) begin
        r.head_valid    = 1'b1;
        r.head_priority = slot_prio[0];
        r.head_client   = slot_client[0];
      end
      r.entry_count = stored[spq_pkg::COUNT_W-1:0];
      r.is_full     = (stored == spq_pkg::CAPACITY);
      r.is_empty    = (stored == 0);
      expected_status.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0d, actual %0d", field, want, seen);
        failures++;
      end
    endfunction

    function void check_status(spq_pkg::result_t got);
      spq_pkg::result_t want;
      if (expected_status.size() == 0) begin
        $error("result transfer with no request outstanding");
        failures++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("head_valid",      want.head_valid,      got.head_valid);
      compare_field("head_priority",   want.head_priority,   got.head_priority);
      compare_field("head_client",     want.head_client,     got.head_client);
      compare_field("popped_valid",    want.popped_valid,    got.popped_valid);
      compare_field("popped_priority", want.popped_priority, got.popped_priority);
      compare_field("popped_client",   want.popped_client,   got.popped_client);
      compare_field("entry_count",     want.entry_count,     got.entry_count);
      compare_field("is_full",         want.is_full,         got.is_full);
      compare_field("is_empty",        want.is_empty,        got.is_empty);
      compare_field("insert_dropped",  want.insert_dropped,  got.insert_dropped);
    endfunction

  endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // random part size and run limit, in cycles
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 300000;

  // burst styles
  localparam int unsigned STYLE_FILL     = 0;
  localparam int unsigned STYLE_DRAIN    = 1;
  localparam int unsigned STYLE_BALANCED = 2;
  localparam int unsigned STYLE_NOISE    = 3;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spq_tb_pkg::spq_scoreboard sb = new();

  // idle shaping: when a quiet flag is set that side inserts no idle gaps
  bit tx_quiet;
  bit rx_quiet;

  int unsigned cycle_count;

  // 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // watchdog on a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one request transfer; entered and left just after a falling edge
  // valid stays high into the next item when no gap is drawn
  task automatic send_item(logic [spq_pkg::OP_W-1:0] op, logic [spq_pkg::PRIO_W-1:0] prio,
                           logic [spq_pkg::CLIENT_W-1:0] client);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.priority_req  <= prio;
    in_ch.client_handle <= client;
    do @(posedge clk); while (!in_ch.ready);
    // transfer seen at this edge, predict before the result can appear
    sb.accept_request(op, prio, client);
    @(negedge clk);
  endtask

  // priority draw: either a narrow band at one end, which makes many ties, or anything
  function automatic logic [spq_pkg::PRIO_W-1:0] draw_prio(bit narrow);
    int unsigned v;
    if (narrow)
      v = ($urandom_range(0, 1) * 248) + $urandom_range(0, 7);
    else
      v = $urandom_range(0, 255);
    return v[spq_pkg::PRIO_W-1:0];
  endfunction

  function automatic logic [spq_pkg::CLIENT_W-1:0] draw_client();
    int unsigned v;
    v = $urandom_range(0, 65535);
    return v[spq_pkg::CLIENT_W-1:0];
  endfunction

  // opcode mix per burst style: fill, drain, balanced, noise
  function automatic logic [spq_pkg::OP_W-1:0] draw_op(int unsigned style);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (style)
      STYLE_FILL:
        return (roll < 80) ? spq_pkg::OP_INSERT : (roll < 97) ? spq_pkg::OP_EXTRACT :
               (roll < 99) ? spq_pkg::OP_CLEAR  : spq_tb_pkg::OP_NOP;
      STYLE_DRAIN:
        return (roll < 20) ? spq_pkg::OP_INSERT : (roll < 97) ? spq_pkg::OP_EXTRACT :
               (roll < 99) ? spq_pkg::OP_CLEAR  : spq_tb_pkg::OP_NOP;
      STYLE_BALANCED:
        return (roll < 50) ? spq_pkg::OP_INSERT : (roll < 96) ? spq_pkg::OP_EXTRACT :
               (roll < 98) ? spq_pkg::OP_CLEAR  : spq_tb_pkg::OP_NOP;
      default:
        return (roll < 33) ? spq_pkg::OP_INSERT : (roll < 66) ? spq_pkg::OP_EXTRACT :
               (roll < 83) ? spq_pkg::OP_CLEAR  : spq_tb_pkg::OP_NOP;
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned style;
    bit          narrow;
    logic [spq_pkg::OP_W-1:0] op;

    // known values on every request input from time zero
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = spq_tb_pkg::OP_NOP;
    in_ch.priority_req  = '0;
    in_ch.client_handle = '0;
    tx_quiet            = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty queue corners
    send_item(spq_pkg::OP_EXTRACT, '0, '0);
    send_item(spq_tb_pkg::OP_NOP, 8'hFF, 16'hFFFF);
    // field extremes and a run of equal priorities that must leave in arrival order
    send_item(spq_pkg::OP_INSERT, 8'hFF, 16'hFFFF);
    send_item(spq_pkg::OP_INSERT, 8'h00, 16'h0000);
    send_item(spq_pkg::OP_INSERT, 8'h80, 16'h1111);
    send_item(spq_pkg::OP_INSERT, 8'h80, 16'h2222);
    send_item(spq_pkg::OP_INSERT, 8'h80, 16'h3333);
    // fill up to capacity
    repeat (spq_pkg::CAPACITY - 5)
      send_item(spq_pkg::OP_INSERT, draw_prio(1'b0), draw_client());
    // insert refused on a full queue, then a no-op while full
    send_item(spq_pkg::OP_INSERT, 8'h01, 16'hABCD);
    send_item(spq_tb_pkg::OP_NOP, 8'h00, 16'h0000);
    send_item(spq_pkg::OP_EXTRACT, '0, '0);
    send_item(spq_pkg::OP_EXTRACT, '0, '0);
    // clear keeps stale slots but nothing is readable afterwards
    send_item(spq_pkg::OP_CLEAR, '0, '0);
    send_item(spq_pkg::OP_EXTRACT, '0, '0);
    send_item(spq_pkg::OP_INSERT, 8'h55, 16'h5A5A);

    // random bursts; no-ops are not counted
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      style    = $urandom_range(STYLE_FILL, STYLE_NOISE);
      burst    = $urandom_range(8, 40);
      narrow   = $urandom_range(0, 1);
      tx_quiet = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        op = draw_op(style);
        send_item(op, draw_prio(narrow), draw_client());
        if (op != spq_tb_pkg::OP_NOP) sent++;
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then a few more edges to catch anything extra
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side: random backpressure, every transfer checked against the oldest prediction
  initial begin
    int unsigned      stall;
    int unsigned      taken;
    spq_pkg::result_t got;

    out_ch.ready = 1'b0;
    rx_quiet     = 1'b0;
    taken        = 0;
    wait (rst_n === 1'b1);
    forever begin
      // redraw the stall style every so often so both long and gap-free stretches occur
      if (taken % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      stall = rx_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.head_valid      = out_ch.head_valid;
      got.head_priority   = out_ch.head_priority;
      got.head_client     = out_ch.head_client;
      got.popped_valid    = out_ch.popped_valid;
      got.popped_priority = out_ch.popped_priority;
      got.popped_client   = out_ch.popped_client;
      got.entry_count     = out_ch.entry_count;
      got.is_full         = out_ch.is_full;
      got.is_empty        = out_ch.is_empty;
      got.insert_dropped  = out_ch.insert_dropped;
      sb.check_status(got);
      taken++;
      @(negedge clk);
    end
  end

endmodule
